// ===== rtl/core/radix_base_converter_unit_macros.svh =====
// Assertion macros shared by the radix base converter RTL.
// Expects signals clk and rst_n in the scope of every use.
`ifndef RADIX_BASE_CONVERTER_UNIT_MACROS_SVH
`define RADIX_BASE_CONVERTER_UNIT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define RBC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("radix converter check failed");

// Same-cycle implication.
`define RBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radix converter check failed");

// Next-cycle implication.
`define RBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radix converter check failed");

`endif

// ===== rtl/core/rbc_pkg.sv =====
// Shared types, constants and digit/character helpers for the radix converter.
// No dependencies.
package rbc_pkg;

  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 6;
  localparam int BASE_W    = 6;
  localparam int ACC_W     = 12;  // acc * base + digit stays below 4096
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_IN_BASE  = 1'b0;
  localparam logic REG_OUT_BASE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd62;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'd122;
  localparam logic [CHAR_W-1:0] UP_OFS   = 8'd10;
  localparam logic [CHAR_W-1:0] LO_OFS   = 8'd36;

  typedef struct packed {
    logic               start;
    logic [ACC_W-1:0]   dividend;
    logic [BASE_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ACC_W-1:0]   quot;
    logic [BASE_W-1:0]  rem;
  } div_rsp_t;

  function automatic logic [DIGIT_W-1:0] char_to_val(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      v = c - CH_UP_A + UP_OFS;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      v = c - CH_LO_A + LO_OFS;
    end
    return v[DIGIT_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] val_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] v;
    logic [CHAR_W-1:0] c;
    v = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (v < UP_OFS) begin
      c = CH_ZERO + v;
    end else if (v < LO_OFS) begin
      c = CH_UP_A + (v - UP_OFS);
    end else begin
      c = CH_LO_A + (v - LO_OFS);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/radix_base_converter_unit.sv =====
// Top level of the radix base converter: digit stores, conversion sequencer
// and stream ports. Depends on rbc_pkg, rbc_div and the assertion macro header.
//
// Use: in_* carries transactions; in_tuser is the op (0 load, 1 read),
// in_tdata the ASCII digit and in_tlast marks the least significant digit
// of a load run, which starts the conversion. Each read returns one out_*
// transaction: out_tdata the ASCII output digit, most significant first,
// out_tlast on the least significant digit, out_tuser set when nothing was
// left to read. cfg_* writes in_base (index 0) and out_base (index 1);
// it and in_tready are high only while the sequencer is idle.
// Timing: a load without in_tlast leaves the sequencer idle. A read holds
// in_tready low until the output register is free, then stores its result
// there, so a new read is taken only once the last one is in the output
// register. A conversion steps through each digit of the current dividend
// per division pass (fetch, multiply-add and the bit-serial divider that all
// passes share: 12 shift steps and a done cycle), plus a pass step per pass
// and one at the end, i.e. quadratic in the digit count.
// Reset: bases go to 10, input and output lengths and read pointer to 0;
// the stores are not cleared. A stalled output holds its data; one further
// read may be taken and waits until the output register frees up.
`include "radix_base_converter_unit_macros.svh"

module radix_base_converter_unit #(
  parameter int unsigned MAX_IN_DIGITS  = 1024,
  parameter int unsigned MAX_OUT_DIGITS = 8192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rbc_pkg::CHAR_W-1:0] in_tdata,   // [7:0] in_char
  input  logic                       in_tuser,   // [0] op
  input  logic                       in_tlast,   // final_digit
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rbc_pkg::CHAR_W-1:0] out_tdata,  // [7:0] out_char
  output logic                       out_tuser,  // [0] none_left
  output logic                       out_tlast,  // last_out
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [rbc_pkg::BASE_W-1:0] cfg_data
);
  import rbc_pkg::*;

  localparam int LW  = $clog2(MAX_IN_DIGITS + 1);
  localparam int IW  = (MAX_IN_DIGITS > 1) ? $clog2(MAX_IN_DIGITS) : 1;
  localparam int OLW = $clog2(MAX_OUT_DIGITS + 1);
  localparam int OW  = $clog2(MAX_OUT_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PASS,
    ST_FETCH,
    ST_MAC,
    ST_DIV
  } state_t;

  state_t              state_r, state_nxt;
  logic [BASE_W-1:0]   in_base_r, in_base_nxt;
  logic [BASE_W-1:0]   out_base_r, out_base_nxt;
  logic [BASE_W-1:0]   ob_r, ob_nxt;
  logic [LW-1:0]       in_len_r, in_len_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [LW-1:0]       i_r, i_nxt;
  logic [LW-1:0]       qlen_r, qlen_nxt;
  logic [OLW-1:0]      cnt_r, cnt_nxt;
  logic [OLW-1:0]      out_len_r, out_len_nxt;
  logic [OLW-1:0]      rp_r, rp_nxt;
  logic [BASE_W-1:0]   acc_r, acc_nxt;
  logic                started_r, started_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_none_r, out_none_nxt;

  logic [DIGIT_W-1:0]  dig_mem [MAX_IN_DIGITS];
  logic [DIGIT_W-1:0]  rem_mem [MAX_OUT_DIGITS];
  logic [DIGIT_W-1:0]  dig_q_r;
  logic [DIGIT_W-1:0]  rem_q_r;
  logic                dig_we;
  logic [IW-1:0]       dig_waddr;
  logic [DIGIT_W-1:0]  dig_wdata;
  logic                rem_we;
  logic [OLW-1:0]      rem_rd_full;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                in_acc;
  logic                cfg_acc;
  logic                in_room;
  logic [LW-1:0]       in_len_inc;
  logic [ACC_W-1:0]    acc_calc;
  logic                started_n;
  logic [LW-1:0]       qlen_n;
  logic [LW-1:0]       i_n;
  logic [BASE_W-1:0]   ob_clamp;

  rbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign in_room    = (in_len_r < LW'(MAX_IN_DIGITS));
  assign in_len_inc = in_room ? (in_len_r + 1'b1) : in_len_r;

  assign ob_clamp = (out_base_r < BASE_MIN) ? BASE_MIN :
                    (out_base_r > BASE_MAX) ? BASE_MAX : out_base_r;

  // acc < ob <= 62 and base <= 63, so the sum stays within ACC_W bits
  assign acc_calc = ACC_W'(acc_r) * ACC_W'(in_base_r) + ACC_W'(dig_q_r);

  assign started_n = started_r || (div_rsp.quot != '0);
  assign qlen_n    = started_n ? (qlen_r + 1'b1) : qlen_r;
  assign i_n       = i_r + 1'b1;

  assign rem_rd_full = out_len_r - 1'b1 - rp_r;

  always_comb begin
    div_req.start    = (state_r == ST_MAC);
    div_req.dividend = acc_calc;
    div_req.divisor  = ob_r;
  end

  always_comb begin
    dig_we    = 1'b0;
    dig_waddr = in_len_r[IW-1:0];
    dig_wdata = char_to_val(in_tdata);
    if (state_r == ST_IDLE) begin
      dig_we = in_acc && (in_tuser == OP_LOAD) && in_room;
    end else if (state_r == ST_DIV) begin
      dig_we    = div_rsp.done && started_n;
      dig_waddr = qlen_r[IW-1:0];
      dig_wdata = div_rsp.quot[DIGIT_W-1:0];
    end
  end

  assign rem_we = (state_r == ST_DIV) && div_rsp.done && (i_n == len_r);

  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[dig_waddr] <= dig_wdata;
    end
    dig_q_r <= dig_mem[i_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[cnt_r[OW-1:0]] <= div_rsp.rem;
    end
    rem_q_r <= rem_mem[rem_rd_full[OW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    in_base_nxt   = in_base_r;
    out_base_nxt  = out_base_r;
    ob_nxt        = ob_r;
    in_len_nxt    = in_len_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    qlen_nxt      = qlen_r;
    cnt_nxt       = cnt_r;
    out_len_nxt   = out_len_r;
    rp_nxt        = rp_r;
    acc_nxt       = acc_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_none_nxt  = out_none_r;

    if (cfg_acc) begin
      unique case (cfg_index)
        REG_IN_BASE:  in_base_nxt  = cfg_data;
        REG_OUT_BASE: out_base_nxt = cfg_data;
        default:      in_base_nxt  = in_base_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_READ) begin
            state_nxt = ST_READ;
          end else begin
            in_len_nxt = in_len_inc;
            if (in_tlast) begin
              len_nxt   = in_len_inc;
              cnt_nxt   = '0;
              ob_nxt    = ob_clamp;
              state_nxt = ST_PASS;
            end
          end
        end
      end
      ST_READ: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (rp_r < out_len_r) begin
            out_char_nxt = val_to_char(rem_q_r);
            out_last_nxt = ((rp_r + 1'b1) == out_len_r);
            out_none_nxt = 1'b0;
            rp_nxt       = rp_r + 1'b1;
          end else begin
            out_char_nxt = '0;
            out_last_nxt = 1'b0;
            out_none_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (len_r == '0 || cnt_r == OLW'(MAX_OUT_DIGITS)) begin
          out_len_nxt = cnt_r;
          rp_nxt      = '0;
          in_len_nxt  = '0;
          state_nxt   = ST_IDLE;
        end else begin
          i_nxt       = '0;
          qlen_nxt    = '0;
          acc_nxt     = '0;
          started_nxt = 1'b0;
          state_nxt   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          started_nxt = started_n;
          qlen_nxt    = qlen_n;
          acc_nxt     = div_rsp.rem;
          i_nxt       = i_n;
          if (i_n == len_r) begin
            cnt_nxt   = cnt_r + 1'b1;
            len_nxt   = qlen_n;
            state_nxt = ST_PASS;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_base_r   <= BASE_RESET;
      out_base_r  <= BASE_RESET;
      in_len_r    <= '0;
      out_len_r   <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_base_r   <= in_base_nxt;
      out_base_r  <= out_base_nxt;
      in_len_r    <= in_len_nxt;
      out_len_r   <= out_len_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ob_r       <= ob_nxt;
    len_r      <= len_nxt;
    i_r        <= i_nxt;
    qlen_r     <= qlen_nxt;
    acc_r      <= acc_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_none_r <= out_none_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_none_r;

  `RBC_ASSERT_ALWAYS(a_rp_bound, rp_r <= out_len_r)
  `RBC_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= OLW'(MAX_OUT_DIGITS))
  `RBC_ASSERT_IMP(a_qlen_behind, state_r == ST_FETCH, qlen_r <= i_r)
  `RBC_ASSERT_IMP(a_div_done_state, div_rsp.done, state_r == ST_DIV)

endmodule

// ===== rtl/core/rbc_div.sv =====
// Bit-serial restoring divider: 12-bit dividend by 6-bit divisor.
// Depends on rbc_pkg and the assertion macro header.
`include "radix_base_converter_unit_macros.svh"

module rbc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rbc_pkg::div_req_t req,
  output rbc_pkg::div_rsp_t rsp
);
  import rbc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0]     num_r, num_nxt;
  logic [ACC_W-1:0]     quot_r, quot_nxt;
  logic [BASE_W-1:0]    rem_r, rem_nxt;
  logic [BASE_W-1:0]    dvs_r, dvs_nxt;
  logic [BASE_W:0]      shifted;
  logic [BASE_W:0]      diff;
  logic                 qbit;

  assign shifted = {rem_r, num_r[ACC_W-1]};
  assign qbit    = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in BASE_W bits
      rem_nxt  = qbit ? diff[BASE_W-1:0] : shifted[BASE_W-1:0];
      quot_nxt = {quot_r[ACC_W-2:0], qbit};
      num_nxt  = {num_r[ACC_W-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

  `RBC_ASSERT_NXT(a_start_busy, req.start, busy_r)
  `RBC_ASSERT_IMP(a_no_restart, req.start, !busy_r)
  `RBC_ASSERT_IMP(a_rem_below_dvs, done_r, rem_r < dvs_r)

endmodule
